FILE: rtl/two_pool_bitmap_id_allocator_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the two-pool id allocator
// Concurrent checks, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef TWO_POOL_BITMAP_ID_ALLOCATOR_UNIT_ASSERT_SVH
`define TWO_POOL_BITMAP_ID_ALLOCATOR_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define TPBA_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("tpba assertion failed");
`define TPBA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tpba assertion failed");
`define TPBA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tpba assertion failed");
`else
`define TPBA_ASSERT_NEVER(lbl, expr)
`define TPBA_ASSERT_IMPL(lbl, ante, cons)
`define TPBA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/tpba_pkg.sv
// ----------------------------------------------------------------------------
// Two-pool id allocator package
// Shared codes, widths and control structures.
// ----------------------------------------------------------------------------
package tpba_pkg;

  localparam int unsigned ID_W    = 16;
  localparam int unsigned BASE_W  = 15;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_DEVICE_ID = 2'd0,
    CMD_ALLOC     = 2'd1,
    CMD_FREE      = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOT_REG = 2'd2,
    ST_RANGE   = 2'd3
  } status_e;

  localparam logic [CFG_IDX_W-1:0] CFG_COMMON_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPECIAL_BASE = 2'd1;

  localparam logic [BASE_W-1:0] COMMON_BASE_RST  = 15'd1;
  localparam logic [BASE_W-1:0] SPECIAL_BASE_RST = 15'd256;

  typedef struct packed {
    logic load_req;
    logic execute;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

  typedef struct packed {
    logic alloc_en;
    logic free_en;
  } pool_cmd_t;

endpackage

FILE: rtl/tpba_if.sv
// ----------------------------------------------------------------------------
// Two-pool id allocator channels
// Request, response and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
interface tpba_req_if;
  logic                        valid;
  logic                        ready;
  logic [tpba_pkg::CMD_W-1:0]  cmd;
  logic                        pool_select;
  logic [tpba_pkg::ID_W-1:0]   release_id;

  modport source (output valid, cmd, pool_select, release_id, input ready);
  modport sink (input valid, cmd, pool_select, release_id, output ready);
endinterface

interface tpba_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [tpba_pkg::ID_W-1:0] result_id;
  logic [1:0]                status;

  modport source (output valid, result_id, status, input ready);
  modport sink (input valid, result_id, status, output ready);
endinterface

interface tpba_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [tpba_pkg::CFG_IDX_W-1:0]  index;
  logic [tpba_pkg::BASE_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/tpba_pool.sv
// ----------------------------------------------------------------------------
// Id pool
// Free bitmap with a lowest-free-slot encoder and a release range check.
// ----------------------------------------------------------------------------
module tpba_pool #(
  parameter int unsigned SLOTS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tpba_pkg::pool_cmd_t           cmd_i,
  input  logic [tpba_pkg::BASE_W-1:0]   base_i,
  input  logic [tpba_pkg::ID_W-1:0]     rid_i,
  output logic                          found_o,
  output logic [tpba_pkg::ID_W-1:0]     alloc_id_o,
  output tpba_pkg::status_e             free_status_o
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned OW = tpba_pkg::ID_W + 1;

  logic [SLOTS-1:0] map_q, map_d;
  logic [IW-1:0]    slot;
  logic [OW-1:0]    off;
  logic [IW-1:0]    off_idx;
  logic             below;
  logic             in_range;
  logic             used;

  always_comb begin
    found_o = 1'b0;
    slot    = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (map_q[i]) begin
        found_o = 1'b1;
        slot    = IW'(i);
      end
    end
  end

  assign alloc_id_o = {1'b0, base_i} + tpba_pkg::ID_W'(slot);

  assign below    = rid_i < {1'b0, base_i};
  assign off      = {1'b0, rid_i} - {2'b00, base_i};
  assign in_range = !below && (off < OW'(SLOTS));
  assign off_idx  = off[IW-1:0];
  assign used     = in_range && !map_q[off_idx];

  always_comb begin
    if (!in_range) begin
      free_status_o = tpba_pkg::ST_RANGE;
    end else if (!used) begin
      free_status_o = tpba_pkg::ST_NOT_REG;
    end else begin
      free_status_o = tpba_pkg::ST_OK;
    end
  end

  always_comb begin
    map_d = map_q;
    if (cmd_i.alloc_en && found_o) begin
      map_d[slot] = 1'b0;
    end
    if (cmd_i.free_en && used) begin
      map_d[off_idx] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q <= '1;
    end else begin
      map_q <= map_d;
    end
  end

endmodule

FILE: rtl/tpba_datapath.sv
// ----------------------------------------------------------------------------
// Two-pool id allocator datapath
// Request register, base registers, device counter, pools and result register.
// ----------------------------------------------------------------------------
module tpba_datapath #(
  parameter int unsigned COMMON_SLOTS  = 32,
  parameter int unsigned SPECIAL_SLOTS = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  tpba_pkg::ctrl_cmd_t             ctrl_i,
  output tpba_pkg::dp_status_t            status_o,
  input  logic [tpba_pkg::CMD_W-1:0]      cmd_i,
  input  logic                            pool_select_i,
  input  logic [tpba_pkg::ID_W-1:0]       release_id_i,
  input  logic                            cfg_we_i,
  input  logic [tpba_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tpba_pkg::BASE_W-1:0]     cfg_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [tpba_pkg::ID_W-1:0]       result_id_o,
  output logic [1:0]                      status_res_o
);

  logic [tpba_pkg::CMD_W-1:0]  cmd_q;
  logic                        pool_q;
  logic [tpba_pkg::ID_W-1:0]   rid_q;
  logic [tpba_pkg::BASE_W-1:0] common_base_q, special_base_q;
  logic [tpba_pkg::ID_W-1:0]   dev_cnt_q, dev_cnt_d;
  logic                        out_valid_q, out_valid_d;
  logic [tpba_pkg::ID_W-1:0]   result_id_q, result_id_d;
  tpba_pkg::status_e           status_q, status_d;

  tpba_pkg::pool_cmd_t         common_cmd, special_cmd;
  logic                        common_found, special_found;
  logic [tpba_pkg::ID_W-1:0]   common_id, special_id;
  tpba_pkg::status_e           common_free_st, special_free_st;
  logic                        is_alloc, is_free;

  assign is_alloc = ctrl_i.execute && (cmd_q == tpba_pkg::CMD_ALLOC);
  assign is_free  = ctrl_i.execute && (cmd_q == tpba_pkg::CMD_FREE);

  assign common_cmd.alloc_en  = is_alloc && !pool_q;
  assign common_cmd.free_en   = is_free && !pool_q;
  assign special_cmd.alloc_en = is_alloc && pool_q;
  assign special_cmd.free_en  = is_free && pool_q;

  tpba_pool #(.SLOTS(COMMON_SLOTS)) u_common (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (common_cmd),
    .base_i        (common_base_q),
    .rid_i         (rid_q),
    .found_o       (common_found),
    .alloc_id_o    (common_id),
    .free_status_o (common_free_st)
  );

  tpba_pool #(.SLOTS(SPECIAL_SLOTS)) u_special (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (special_cmd),
    .base_i        (special_base_q),
    .rid_i         (rid_q),
    .found_o       (special_found),
    .alloc_id_o    (special_id),
    .free_status_o (special_free_st)
  );

  always_comb begin
    dev_cnt_d   = dev_cnt_q;
    result_id_d = '0;
    status_d    = tpba_pkg::ST_OK;
    case (cmd_q)
      tpba_pkg::CMD_DEVICE_ID: begin
        result_id_d = dev_cnt_q;
        if (ctrl_i.execute) begin
          dev_cnt_d = dev_cnt_q + 16'd1;
        end
      end
      tpba_pkg::CMD_ALLOC: begin
        if (pool_q ? special_found : common_found) begin
          result_id_d = pool_q ? special_id : common_id;
        end else begin
          status_d = tpba_pkg::ST_FULL;
        end
      end
      tpba_pkg::CMD_FREE: begin
        status_d = pool_q ? special_free_st : common_free_st;
      end
      default: begin
        result_id_d = '0;
      end
    endcase
  end

  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_i.execute) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q    <= 1'b0;
      dev_cnt_q      <= '0;
      common_base_q  <= tpba_pkg::COMMON_BASE_RST;
      special_base_q <= tpba_pkg::SPECIAL_BASE_RST;
    end else begin
      out_valid_q <= out_valid_d;
      dev_cnt_q   <= dev_cnt_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          tpba_pkg::CFG_COMMON_BASE:  common_base_q  <= cfg_data_i;
          tpba_pkg::CFG_SPECIAL_BASE: special_base_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_req) begin
      cmd_q  <= cmd_i;
      pool_q <= pool_select_i;
      rid_q  <= release_id_i;
    end
    if (ctrl_i.execute) begin
      result_id_q <= result_id_d;
      status_q    <= status_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign result_id_o  = result_id_q;
  assign status_res_o = status_q;

endmodule

FILE: rtl/tpba_ctrl.sv
// ----------------------------------------------------------------------------
// Two-pool id allocator controller
// Takes a request, then runs it once the result register can take a beat.
// ----------------------------------------------------------------------------
module tpba_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  tpba_pkg::dp_status_t  status_i,
  output tpba_pkg::ctrl_cmd_t   ctrl_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d          = state_q;
    in_ready_o       = 1'b0;
    ctrl_o.load_req  = 1'b0;
    ctrl_o.execute   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o      = 1'b1;
        ctrl_o.load_req = in_valid_i;
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (status_i.out_free) begin
          ctrl_o.execute = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/two_pool_bitmap_id_allocator_unit.sv
// ----------------------------------------------------------------------------
// Two-pool bitmap id allocator
// A request beat is first registered; then an allocation runs through the
// lowest-free-slot encoder of the chosen pool, a free through its range check
// or a device-id request through the device counter, and the result register
// is loaded. A new request is taken only once the last one has run. The
// execute step waits only while the result register still holds a beat that
// has not been taken. The next request is accepted while a finished result
// waits. Base registers go through the cfg channel, which is always ready.
// ----------------------------------------------------------------------------
`include "two_pool_bitmap_id_allocator_unit_assert.svh"

module two_pool_bitmap_id_allocator_unit #(
  parameter int unsigned COMMON_SLOTS  = 32,
  parameter int unsigned SPECIAL_SLOTS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  tpba_req_if.sink    req,
  tpba_rsp_if.source  rsp,
  tpba_cfg_if.sink    cfg
);

  tpba_pkg::ctrl_cmd_t  ctrl;
  tpba_pkg::dp_status_t dp_status;

  assign cfg.ready = 1'b1;

  tpba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req.valid),
    .in_ready_o (req.ready),
    .status_i   (dp_status),
    .ctrl_o     (ctrl)
  );

  tpba_datapath #(
    .COMMON_SLOTS  (COMMON_SLOTS),
    .SPECIAL_SLOTS (SPECIAL_SLOTS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .status_o      (dp_status),
    .cmd_i         (req.cmd),
    .pool_select_i (req.pool_select),
    .release_id_i  (req.release_id),
    .cfg_we_i      (cfg.valid),
    .cfg_index_i   (cfg.index),
    .cfg_data_i    (cfg.data),
    .out_valid_o   (rsp.valid),
    .out_ready_i   (rsp.ready),
    .result_id_o   (rsp.result_id),
    .status_res_o  (rsp.status)
  );

  `TPBA_ASSERT_NEXT(a_one_req_in_flight, req.valid && req.ready, !req.ready)
  `TPBA_ASSERT_IMPL(a_result_follows_req, $rose(rsp.valid), $past(!req.ready))
  `TPBA_ASSERT_NEVER(a_full_gives_zero,
    rsp.valid && (rsp.status == tpba_pkg::ST_FULL) && (rsp.result_id != '0))

endmodule
